// File: hw/rtl/qssf_pkg.sv
`default_nettype none
package qssf_pkg;

    // Defaults for the screen geometry.
    localparam int SCREEN_WIDTH_DEF    = 320;
    localparam int SCREEN_LAST_ROW_DEF = 199;

    // Coordinate, quotient, numerator and crossing widths.
    localparam int CW = 11;
    localparam int QW = 11;
    localparam int NW = 22;
    localparam int XW = 13;

    localparam int NUM_EDGES    = 4;
    localparam int SETUP_STAGES = 3;
    localparam int DIV_STAGES   = QW;
    localparam int SIDE_DEPTH   = SETUP_STAGES + DIV_STAGES;

    // One edge on its way through the divider.
    typedef struct packed {
        logic [NW-1:0]        num;
        logic [QW-1:0]        den;
        logic                 neg;
        logic                 part;
        logic signed [CW-1:0] xa;
    } t_div_in;

    // Per-item fields that ride beside the edge pipelines.
    typedef struct packed {
        logic                 valid;
        logic                 row_ok;
        logic [7:0]           row;
        logic [7:0]           color;
        logic [15:0]          buffer;
    } t_side;

endpackage
`default_nettype wire

// File: hw/rtl/qssf_edge.sv
`default_nettype none
module qssf_edge (
    input  wire logic                          i_clk,
    input  wire logic signed [qssf_pkg::CW-1:0] i_xa,
    input  wire logic signed [qssf_pkg::CW-1:0] i_ya,
    input  wire logic signed [qssf_pkg::CW-1:0] i_xb,
    input  wire logic signed [qssf_pkg::CW-1:0] i_yb,
    input  wire logic signed [qssf_pkg::CW-1:0] i_row,
    output qssf_pkg::t_div_in                  o_div
);
    import qssf_pkg::*;

    // Stage 1: differences and the span test.
    logic signed [CW:0]   r_dy, r_dx, r_rr;
    logic                 r_part1;
    logic signed [CW-1:0] r_xa1;
    // Stage 2: product.
    logic signed [2*CW+1:0] r_prod;
    logic signed [CW:0]     r_dy2;
    logic                   r_part2;
    logic signed [CW-1:0]   r_xa2;
    // Stage 3: magnitudes and quotient sign.
    t_div_in r_div;

    logic signed [CW:0]     n_dy, n_dx, n_rr;
    logic                   n_part;
    logic signed [2*CW+1:0] n_prod, n_pmag;
    logic signed [CW:0]     n_dmag;

    always_comb begin
        n_dy   = (CW+1)'(i_yb) - (CW+1)'(i_ya);
        n_dx   = (CW+1)'(i_xb) - (CW+1)'(i_xa);
        n_rr   = (CW+1)'(i_row) - (CW+1)'(i_ya);
        n_part = (i_ya != i_yb) && ((i_ya >= i_row) || (i_yb >= i_row))
                 && ((i_ya <= i_row) || (i_yb <= i_row));
        n_prod = r_rr * r_dx;
        n_pmag = r_prod[2*CW+1] ? -r_prod : r_prod;
        n_dmag = r_dy2[CW] ? -r_dy2 : r_dy2;
    end

    always_ff @(posedge i_clk) begin
        r_dy    <= n_dy;
        r_dx    <= n_dx;
        r_rr    <= n_rr;
        r_part1 <= n_part;
        r_xa1   <= i_xa;

        r_prod  <= n_prod;
        r_dy2   <= r_dy;
        r_part2 <= r_part1;
        r_xa2   <= r_xa1;

        r_div.num  <= n_pmag[NW-1:0];
        r_div.den  <= n_dmag[QW-1:0];
        r_div.neg  <= r_prod[2*CW+1] ^ r_dy2[CW];
        r_div.part <= r_part2;
        r_div.xa   <= r_xa2;
    end

    assign o_div = r_div;

endmodule
`default_nettype wire

// File: hw/rtl/qssf_div.sv
`default_nettype none
module qssf_div (
    input  wire logic                  i_clk,
    input  qssf_pkg::t_div_in          i_in,
    output logic [qssf_pkg::QW-1:0]    o_q,
    output qssf_pkg::t_div_in          o_info
);
    import qssf_pkg::*;

    // Restoring division, one quotient bit per stage, most significant first.
    // The quotient is known to fit in QW bits because the row lies inside the edge.
    logic [NW-1:0] r_rem  [DIV_STAGES];
    logic [QW-1:0] r_q    [DIV_STAGES];
    t_div_in       r_info [DIV_STAGES];
    logic [NW-1:0] n_rem  [DIV_STAGES];
    logic [QW-1:0] n_q    [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        localparam int K = QW - 1 - s;
        logic [NW-1:0] rem_in;
        logic [QW-1:0] q_in;
        t_div_in       info_in;
        logic [NW-1:0] trial;
        logic          ge;

        if (s == 0) begin : g_first
            assign rem_in  = i_in.num;
            assign q_in    = '0;
            assign info_in = i_in;
        end else begin : g_next
            assign rem_in  = r_rem[s-1];
            assign q_in    = r_q[s-1];
            assign info_in = r_info[s-1];
        end

        always_comb begin
            trial    = NW'(info_in.den) << K;
            ge       = rem_in >= trial;
            n_rem[s] = ge ? rem_in - trial : rem_in;
            n_q[s]   = q_in | (QW'(ge) << K);
        end

        always_ff @(posedge i_clk) begin
            r_rem[s]  <= n_rem[s];
            r_q[s]    <= n_q[s];
            r_info[s] <= info_in;
        end
    end

    assign o_q    = r_q[DIV_STAGES-1];
    assign o_info = r_info[DIV_STAGES-1];

endmodule
`default_nettype wire

// File: hw/rtl/qssf_span.sv
`default_nettype none
module qssf_span #(
    parameter int SCREEN_WIDTH = qssf_pkg::SCREEN_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [qssf_pkg::QW-1:0] i_q [qssf_pkg::NUM_EDGES],
    input  qssf_pkg::t_div_in         i_info [qssf_pkg::NUM_EDGES],
    input  qssf_pkg::t_side           i_side,
    output logic                      o_valid,
    output logic [7:0]                o_row,
    output logic [8:0]                o_start,
    output logic [8:0]                o_end,
    output logic [7:0]                o_color,
    output logic [15:0]               o_buffer
);
    import qssf_pkg::*;

    localparam logic signed [XW-1:0] W_S    = XW'(SCREEN_WIDTH);
    localparam logic signed [XW-1:0] LAST_S = XW'(SCREEN_WIDTH - 1);

    logic signed [XW-1:0] r_x    [NUM_EDGES];
    logic                 r_part [NUM_EDGES];
    t_side                r_side;
    t_side                n_side;
    logic signed [XW-1:0] n_x    [NUM_EDGES];

    logic                 r_valid;
    logic [7:0]           r_row, r_color;
    logic [8:0]           r_start, r_end;
    logic [15:0]          r_buffer;

    logic signed [XW-1:0] n_lo, n_hi;
    logic                 n_emit;

    // Sign the quotient and add the start column of the edge.
    always_comb begin
        for (int e = 0; e < NUM_EDGES; e++) begin
            n_x[e] = XW'(i_info[e].xa)
                     + (i_info[e].neg ? -$signed(XW'(i_q[e])) : $signed(XW'(i_q[e])));
        end
    end

    // The valid bit is cleared while reset is held.
    always_comb begin
        n_side       = i_side;
        n_side.valid = i_side.valid && i_rst_n;
    end

    // Least and greatest crossing, then the clamp to the screen.
    always_comb begin
        n_lo = W_S;
        n_hi = -XW'(1);
        for (int e = 0; e < NUM_EDGES; e++) begin
            if (r_part[e] && (r_x[e] < n_lo)) begin
                n_lo = r_x[e];
            end
            if (r_part[e] && (r_x[e] > n_hi)) begin
                n_hi = r_x[e];
            end
        end
        if (n_lo < 0) begin
            n_lo = '0;
        end
        if (n_hi > LAST_S) begin
            n_hi = LAST_S;
        end
        n_emit = r_side.valid && r_side.row_ok && (n_lo <= n_hi);
    end

    always_ff @(posedge i_clk) begin
        for (int e = 0; e < NUM_EDGES; e++) begin
            r_x[e]    <= n_x[e];
            r_part[e] <= i_info[e].part;
        end
        r_side   <= n_side;
        r_valid  <= n_emit && i_rst_n;
        r_row    <= r_side.row;
        r_start  <= n_lo[8:0];
        r_end    <= n_hi[8:0];
        r_color  <= r_side.color;
        r_buffer <= r_side.buffer;
    end

    assign o_valid  = r_valid;
    assign o_row    = r_row;
    assign o_start  = r_start;
    assign o_end    = r_end;
    assign o_color  = r_color;
    assign o_buffer = r_buffer;

endmodule
`default_nettype wire

// File: hw/rtl/quad_scanline_span_fill_unit.sv
// Each item passes the edge setup, the divider and the crossing merge before its span appears.
// Throughput: one item per cycle; busy stays low, so start may be held high every cycle.
// The depth is set by the edge setup (3 stages), the 11-stage bit-per-stage divider
// and the crossing merge (2 stages). Each span is strobed by o_valid for one cycle.
// Reset (synchronous, active low) clears all valid bits; items in flight are dropped.
// The receiver cannot stall, so no output buffering is needed.
`default_nettype none
module quad_scanline_span_fill_unit #(
    parameter int SCREEN_WIDTH    = qssf_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_LAST_ROW = qssf_pkg::SCREEN_LAST_ROW_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic signed [10:0] i_vert0_x,
    input  wire logic signed [10:0] i_vert0_y,
    input  wire logic signed [10:0] i_vert1_x,
    input  wire logic signed [10:0] i_vert1_y,
    input  wire logic signed [10:0] i_vert2_x,
    input  wire logic signed [10:0] i_vert2_y,
    input  wire logic signed [10:0] i_vert3_x,
    input  wire logic signed [10:0] i_vert3_y,
    input  wire logic [7:0]  i_fill_color,
    input  wire logic [15:0] i_target_buffer,
    input  wire logic signed [10:0] i_scan_row,
    output logic             o_valid,
    output logic [7:0]       o_span_row,
    output logic [8:0]       o_span_start,
    output logic [8:0]       o_span_end,
    output logic [7:0]       o_span_color,
    output logic [15:0]      o_span_buffer
);
    import qssf_pkg::*;

    // The block is fully pipelined and never refuses an item.
    assign busy = 1'b0;

    logic signed [CW-1:0] vx [NUM_EDGES];
    logic signed [CW-1:0] vy [NUM_EDGES];

    assign vx[0] = i_vert0_x;
    assign vy[0] = i_vert0_y;
    assign vx[1] = i_vert1_x;
    assign vy[1] = i_vert1_y;
    assign vx[2] = i_vert2_x;
    assign vy[2] = i_vert2_y;
    assign vx[3] = i_vert3_x;
    assign vy[3] = i_vert3_y;

    t_div_in       div_in   [NUM_EDGES];
    t_div_in       div_info [NUM_EDGES];
    logic [QW-1:0] div_q    [NUM_EDGES];

    // Each closed edge runs from vertex e to the next vertex, wrapping around.
    for (genvar e = 0; e < NUM_EDGES; e++) begin : g_edge
        localparam int J = (e + 1) % NUM_EDGES;

        qssf_edge u_edge (
            .i_clk (i_clk),
            .i_xa  (vx[e]),
            .i_ya  (vy[e]),
            .i_xb  (vx[J]),
            .i_yb  (vy[J]),
            .i_row (i_scan_row),
            .o_div (div_in[e])
        );

        qssf_div u_div (
            .i_clk  (i_clk),
            .i_in   (div_in[e]),
            .o_q    (div_q[e]),
            .o_info (div_info[e])
        );
    end

    // The row test, the color and the buffer tag travel beside the edge pipelines
    // so they meet the quotients at the divider outputs.
    t_side r_side [SIDE_DEPTH];
    t_side n_side [SIDE_DEPTH];
    t_side n_side0;

    always_comb begin
        n_side0.valid  = start && i_rst_n;
        n_side0.row_ok = (i_scan_row >= 0)
                         && ((CW+1)'(i_scan_row) <= $signed((CW+1)'(SCREEN_LAST_ROW)));
        n_side0.row    = i_scan_row[7:0];
        n_side0.color  = i_fill_color;
        n_side0.buffer = i_target_buffer;
    end

    // Every valid bit along the side pipeline is cleared while reset is held.
    always_comb begin
        n_side[0] = n_side0;
        for (int i = 1; i < SIDE_DEPTH; i++) begin
            n_side[i]       = r_side[i-1];
            n_side[i].valid = r_side[i-1].valid && i_rst_n;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < SIDE_DEPTH; i++) begin
            r_side[i] <= n_side[i];
        end
    end

    qssf_span #(
        .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_span (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q      (div_q),
        .i_info   (div_info),
        .i_side   (r_side[SIDE_DEPTH-1]),
        .o_valid  (o_valid),
        .o_row    (o_span_row),
        .o_start  (o_span_start),
        .o_end    (o_span_end),
        .o_color  (o_span_color),
        .o_buffer (o_span_buffer)
    );

    // A span can only come from an item that was accepted and has passed the whole pipeline.
    a_span_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 16))
        else $error("span without a matching item");

    // Emitted spans are ordered and lie on the screen.
    a_span_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (SCREEN_WIDTH <= 512)) |->
            ((o_span_start <= o_span_end) && (32'(o_span_end) < SCREEN_WIDTH)))
        else $error("span out of order or off screen");

    // The emitted row passed the screen row test.
    a_span_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (SCREEN_LAST_ROW <= 255)) |-> (32'(o_span_row) <= SCREEN_LAST_ROW))
        else $error("span row off screen");

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import qssf_pkg::*;

    // One scanline request as it goes onto the ports.
    typedef struct {
        logic signed [10:0] vx [4];
        logic signed [10:0] vy [4];
        logic [7:0]         color;
        logic [15:0]        buffer;
        logic signed [10:0] row;
    } t_quad_row;

    // One span as it comes off the ports.
    typedef struct {
        logic [7:0]  row;
        logic [8:0]  first_col;
        logic [8:0]  last_col;
        logic [7:0]  color;
        logic [15:0] buffer;
    } t_span;

    // How a directed row is checked: through the predictor, as a row that gives
    // no span, or against the span typed into the table.
    typedef enum int {BY_PREDICTOR, NO_SPAN, TYPED_SPAN} t_check_kind;

    typedef struct {
        t_quad_row   req;
        t_check_kind kind;
        t_span       span;
    } t_directed_row;

    localparam int SCREEN_W      = 320;
    localparam int LAST_ROW      = 199;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RANDOM_ITEMS  = 1030;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [10:0] i_vert0_x, i_vert0_y, i_vert1_x, i_vert1_y;
    logic signed [10:0] i_vert2_x, i_vert2_y, i_vert3_x, i_vert3_y;
    logic [7:0]         i_fill_color;
    logic [15:0]        i_target_buffer;
    logic signed [10:0] i_scan_row;
    logic               o_valid;
    logic [7:0]         o_span_row;
    logic [8:0]         o_span_start;
    logic [8:0]         o_span_end;
    logic [7:0]         o_span_color;
    logic [15:0]        o_span_buffer;

    quad_scanline_span_fill_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_vert0_x       (i_vert0_x),
        .i_vert0_y       (i_vert0_y),
        .i_vert1_x       (i_vert1_x),
        .i_vert1_y       (i_vert1_y),
        .i_vert2_x       (i_vert2_x),
        .i_vert2_y       (i_vert2_y),
        .i_vert3_x       (i_vert3_x),
        .i_vert3_y       (i_vert3_y),
        .i_fill_color    (i_fill_color),
        .i_target_buffer (i_target_buffer),
        .i_scan_row      (i_scan_row),
        .o_valid         (o_valid),
        .o_span_row      (o_span_row),
        .o_span_start    (o_span_start),
        .o_span_end      (o_span_end),
        .o_span_color    (o_span_color),
        .o_span_buffer   (o_span_buffer)
    );

    // Spans still owed by the block, oldest first.
    t_span pending_spans [$];
    int    mismatches  = 0;
    int    idle_cycles = 0;
    bit    item_taken;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Works out the span of one row. Each closed edge that is not horizontal and
    // whose end rows enclose the row adds a crossing column; SystemVerilog integer
    // division truncates toward zero, which is the rounding the block must follow.
    function automatic bit predict_span(input t_quad_row q, output t_span s);
        int r, lo, hi, xa, ya, xb, yb, x, j;
        r  = int'(q.row);
        lo = SCREEN_W;
        hi = -1;
        s  = '{default: '0};
        if (r < 0 || r > LAST_ROW) return 1'b0;
        for (int i = 0; i < 4; i++) begin
            j  = (i + 1) % 4;
            xa = int'(q.vx[i]);
            ya = int'(q.vy[i]);
            xb = int'(q.vx[j]);
            yb = int'(q.vy[j]);
            if (ya == yb) continue;
            if (!((ya >= r || yb >= r) && (ya <= r || yb <= r))) continue;
            x = (r - ya) * (xb - xa) / (yb - ya) + xa;
            if (x < lo) lo = x;
            if (x > hi) hi = x;
        end
        if (lo < 0) lo = 0;
        if (hi > SCREEN_W - 1) hi = SCREEN_W - 1;
        if (lo > hi) return 1'b0;
        s.row       = r[7:0];
        s.first_col = lo[8:0];
        s.last_col  = hi[8:0];
        s.color     = q.color;
        s.buffer    = q.buffer;
        return 1'b1;
    endfunction

    function automatic t_quad_row make_quad(input int x0, y0, x1, y1, x2, y2, x3, y3,
                                            input int color, buffer, row);
        t_quad_row q;
        q.vx[0] = 11'(x0); q.vy[0] = 11'(y0);
        q.vx[1] = 11'(x1); q.vy[1] = 11'(y1);
        q.vx[2] = 11'(x2); q.vy[2] = 11'(y2);
        q.vx[3] = 11'(x3); q.vy[3] = 11'(y3);
        q.color  = 8'(color);
        q.buffer = 16'(buffer);
        q.row    = 11'(row);
        return q;
    endfunction

    function automatic t_directed_row dir_row(input t_quad_row q, input t_check_kind k,
                                              input int srow = 0, first = 0, last = 0);
        t_directed_row d;
        d.req  = q;
        d.kind = k;
        d.span = '{row: 8'(srow), first_col: 9'(first), last_col: 9'(last),
                   color: q.color, buffer: q.buffer};
        return d;
    endfunction

    // Random coordinates: mostly near the screen so that edges really cross
    // visible rows, sometimes anywhere in the 11-bit range.
    function automatic int rand_coord(input int lo_near, input int hi_near);
        if ($urandom_range(0, 9) < 8)
            return int'($urandom_range(0, hi_near - lo_near)) + lo_near;
        return int'($urandom_range(0, 2047)) - 1024;
    endfunction

    function automatic t_quad_row random_quad();
        t_quad_row q;
        int        mode;
        mode = int'($urandom_range(0, 9));
        for (int i = 0; i < 4; i++) begin
            q.vx[i] = 11'(rand_coord(-120, 440));
            q.vy[i] = 11'(rand_coord(-60, 260));
        end
        // Now and then two neighbors share a row, giving a horizontal edge.
        if (mode == 0) q.vy[1] = q.vy[0];
        if (mode == 1) q.vy[3] = q.vy[2];
        q.color  = 8'($urandom_range(0, 255));
        q.buffer = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 9) < 8) q.row = 11'($urandom_range(0, LAST_ROW));
        else q.row = 11'(int'($urandom_range(0, 2047)) - 1024);
        return q;
    endfunction

    // Idle gaps before an item: mostly none or short, a few long.
    function automatic int gap_cycles();
        int p;
        p = int'($urandom_range(0, 99));
        if (p < 50) return 0;
        if (p < 90) return int'($urandom_range(1, 3));
        return int'($urandom_range(10, 40));
    endfunction

    task automatic put_on_ports(input t_quad_row q);
        start           <= 1'b1;
        i_vert0_x       <= q.vx[0];
        i_vert0_y       <= q.vy[0];
        i_vert1_x       <= q.vx[1];
        i_vert1_y       <= q.vy[1];
        i_vert2_x       <= q.vx[2];
        i_vert2_y       <= q.vy[2];
        i_vert3_x       <= q.vx[3];
        i_vert3_y       <= q.vy[3];
        i_fill_color    <= q.color;
        i_target_buffer <= q.buffer;
        i_scan_row      <= q.row;
    endtask

    // Presents one item, waits for the edge that accepts it and records the span
    // it should produce. Called at a rising edge; returns at the accepting edge,
    // where start is still high, so the next call or a gap may follow at once.
    task automatic send_row(input t_quad_row q, input t_check_kind k, input t_span typed,
                            input int gap);
        t_span s;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        put_on_ports(q);
        do @(posedge i_clk); while (busy);
        case (k)
            TYPED_SPAN: begin
                pending_spans.push_back(typed);
            end
            BY_PREDICTOR: begin
                if (predict_span(q, s)) pending_spans.push_back(s);
            end
            default: begin
            end
        endcase
    endtask

    // Results cannot be held off, so every strobed span is taken at the edge
    // that ends its cycle and checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_span exp_span;
        if (i_rst_n && o_valid) begin
            if (pending_spans.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: span with nothing expected: row %0d cols %0d..%0d",
                             o_span_row, o_span_start, o_span_end);
            end else begin
                exp_span = pending_spans.pop_front();
                if (o_span_row !== exp_span.row || o_span_start !== exp_span.first_col ||
                    o_span_end !== exp_span.last_col || o_span_color !== exp_span.color ||
                    o_span_buffer !== exp_span.buffer) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"tb: span mismatch: expected row %0d cols %0d..%0d ",
                                  "color %0h buf %0h, got row %0d cols %0d..%0d ",
                                  "color %0h buf %0h"},
                                 exp_span.row, exp_span.first_col, exp_span.last_col,
                                 exp_span.color, exp_span.buffer, o_span_row, o_span_start,
                                 o_span_end, o_span_color, o_span_buffer);
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither an item nor a span moved.
    always @(posedge i_clk) begin
        item_taken = i_rst_n && start && !busy;
        if (item_taken || (i_rst_n && o_valid) || !i_rst_n) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        t_directed_row directed [$];
        t_quad_row     q;
        t_span         none_span;
        bit            no_gaps;

        none_span       = '{default: '0};
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_vert0_x       = '0;
        i_vert0_y       = '0;
        i_vert1_x       = '0;
        i_vert1_y       = '0;
        i_vert2_x       = '0;
        i_vert2_y       = '0;
        i_vert3_x       = '0;
        i_vert3_y       = '0;
        i_fill_color    = '0;
        i_target_buffer = '0;
        i_scan_row      = '0;

        // Directed part. The full-screen rectangle has two vertical edges at the
        // screen borders, so its spans can be typed in directly.
        directed.push_back(dir_row(make_quad(0, 0, 319, 0, 319, 199, 0, 199, 0, 0, 0),
                                   TYPED_SPAN, 0, 0, 319));
        directed.push_back(dir_row(make_quad(0, 0, 319, 0, 319, 199, 0, 199, 255, 65535, 199),
                                   TYPED_SPAN, 199, 0, 319));
        // Rows off the screen give nothing.
        directed.push_back(dir_row(make_quad(0, 0, 319, 0, 319, 199, 0, 199, 1, 2, -1),
                                   NO_SPAN));
        directed.push_back(dir_row(make_quad(0, 0, 319, 0, 319, 199, 0, 199, 1, 2, 200),
                                   NO_SPAN));
        directed.push_back(dir_row(make_quad(-1024, -1024, 1023, -1024, 1023, 1023,
                                             -1024, 1023, 3, 4, -1024), NO_SPAN));
        directed.push_back(dir_row(make_quad(-1024, -1024, 1023, -1024, 1023, 1023,
                                             -1024, 1023, 3, 4, 1023), NO_SPAN));
        // Extreme vertices: both crossings lie off the screen and get clamped.
        directed.push_back(dir_row(make_quad(-1024, -1024, 1023, -1024, 1023, 1023,
                                             -1024, 1023, 170, 43690, 100),
                                   TYPED_SPAN, 100, 0, 319));
        // Every edge horizontal, so no edge crosses.
        directed.push_back(dir_row(make_quad(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), NO_SPAN));
        directed.push_back(dir_row(make_quad(5, 50, 300, 50, 10, 50, 200, 50, 7, 7, 50),
                                   NO_SPAN));
        // Row outside the vertex range.
        directed.push_back(dir_row(make_quad(10, 10, 100, 10, 100, 20, 10, 20, 9, 9, 5),
                                   NO_SPAN));
        // All crossings left of, or right of, the screen.
        directed.push_back(dir_row(make_quad(-500, 0, -10, 0, -10, 199, -500, 199, 8, 8, 50),
                                   NO_SPAN));
        directed.push_back(dir_row(make_quad(400, 0, 1000, 0, 1000, 199, 400, 199, 8, 8, 50),
                                   NO_SPAN));
        // Diamond: a single pixel at the top vertex, sloped edges elsewhere.
        directed.push_back(dir_row(make_quad(160, 0, 300, 100, 160, 199, 20, 100, 33, 4660, 0),
                                   TYPED_SPAN, 0, 160, 160));
        for (int r = 33; r <= 199; r += 33)
            directed.push_back(dir_row(make_quad(160, 0, 300, 100, 160, 199, 20, 100,
                                                 r, 1000 + r, r), BY_PREDICTOR));
        // Irregular quad with negative coordinates and both slope signs, where
        // truncation toward zero matters.
        directed.push_back(dir_row(make_quad(-100, -50, 500, 30, 200, 250, -300, 120,
                                             90, 22136, 0), BY_PREDICTOR));
        directed.push_back(dir_row(make_quad(-100, -50, 500, 30, 200, 250, -300, 120,
                                             91, 22137, 77), BY_PREDICTOR));
        directed.push_back(dir_row(make_quad(-100, -50, 500, 30, 200, 250, -300, 120,
                                             92, 22138, 199), BY_PREDICTOR));
        directed.push_back(dir_row(make_quad(7, 3, 1, 190, 318, 197, 313, 1, 93, 1, 121),
                                   BY_PREDICTOR));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i])
            send_row(directed[i].req, directed[i].kind, directed[i].span, gap_cycles());

        // Random part, in stretches that are, at random, either back-to-back items or
        // items with random gaps, so gaps land on every pipeline stage.
        no_gaps = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) no_gaps = $urandom_range(0, 2) == 0;
            q = random_quad();
            send_row(q, BY_PREDICTOR, none_span, no_gaps ? 0 : gap_cycles());
        end
        start <= 1'b0;

        // Let the pipeline drain; the watchdog bounds this wait.
        while (pending_spans.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_spans.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire
